// ===== hdl/bqeq_pkg.sv =====
// Shared constants, types and arithmetic helpers of the biquad cascade equalizer.
// Used by the register file, controller, datapath and top level; no dependencies.
`default_nettype none
package bqeq_pkg;

   localparam int CHANNELS       = 2;
   localparam int BANDS          = 10;
   localparam int COEF_FRAC_BITS = 28;

   localparam int SLOTS     = 5;
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int GAIN_W    = 24;
   localparam int GAIN_FRAC = 20;
   localparam int HIST_W    = 40;
   localparam int SPLIT     = 20;
   localparam int LO_W      = SPLIT + 1 + COEF_W;
   localparam int HI_W      = HIST_W - SPLIT + COEF_W;
   localparam int FULL_W    = HIST_W + COEF_W;
   localparam int ACC_W     = FULL_W - COEF_FRAC_BITS + 2;
   localparam int PRE_W     = SAMPLE_W + GAIN_W + 1;

   localparam int COEF_DEPTH = BANDS * SLOTS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int HIST_DEPTH = CHANNELS * BANDS;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int BAND_CW    = (BANDS > 1) ? $clog2(BANDS) : 1;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1048576);

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_COEF   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic REG_PREAMP_GAIN = 1'b0;
   localparam logic REG_EQ_ENABLE   = 1'b1;

   // product order within one band
   localparam logic [2:0] STEP_B0X = 3'd0;
   localparam logic [2:0] STEP_B1X = 3'd1;
   localparam logic [2:0] STEP_A1Y = 3'd2;
   localparam logic [2:0] STEP_B2X = 3'd3;
   localparam logic [2:0] STEP_A2Y = 3'd4;

   localparam logic [2:0] SLOT_B0 = 3'd0;
   localparam logic [2:0] SLOT_B1 = 3'd1;
   localparam logic [2:0] SLOT_B2 = 3'd2;
   localparam logic [2:0] SLOT_A1 = 3'd3;
   localparam logic [2:0] SLOT_A2 = 3'd4;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_PRE  = 9'b000000010,
      ST_RD   = 9'b000000100,
      ST_MLO  = 9'b000001000,
      ST_MHI  = 9'b000010000,
      ST_RND  = 9'b000100000,
      ST_ACC  = 9'b001000000,
      ST_WB   = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic               accept;
      logic               pre;
      logic               hist_rd;
      logic               coef_rd;
      logic               mul_lo;
      logic               mul_hi;
      logic               round;
      logic               acc;
      logic               wb;
      logic               out_load;
      logic [BAND_CW-1:0] band;
      logic [2:0]         step;
      logic [2:0]         coef_step;
   } cmd_type;

   typedef struct packed {
      logic sample_ok;
      logic run_eq;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic                     clip;
      logic signed [HIST_W-1:0] val;
   } hsat_type;

   typedef struct packed {
      logic                       clip;
      logic signed [SAMPLE_W-1:0] val;
   } osat_type;

   function automatic logic [2:0] step_slot(input logic [2:0] step);
      logic [2:0] slot;
      case (step)
         STEP_B0X: slot = SLOT_B0;
         STEP_B1X: slot = SLOT_B1;
         STEP_A1Y: slot = SLOT_A1;
         STEP_B2X: slot = SLOT_B2;
         STEP_A2Y: slot = SLOT_A2;
         default:  slot = SLOT_B0;
      endcase
      return slot;
   endfunction

   function automatic hsat_type sat_hist(input logic signed [ACC_W-1:0] v);
      hsat_type r;
      r.clip = !((&v[ACC_W-1:HIST_W-1]) || !(|v[ACC_W-1:HIST_W-1]));
      if (r.clip) begin
         r.val = v[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
      end else begin
         r.val = v[HIST_W-1:0];
      end
      return r;
   endfunction

   function automatic osat_type sat_out(input logic signed [HIST_W-1:0] v);
      osat_type r;
      r.clip = !((&v[HIST_W-1:SAMPLE_W-1]) || !(|v[HIST_W-1:SAMPLE_W-1]));
      if (r.clip) begin
         r.val = v[HIST_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         r.val = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/bqeq_csr.sv =====
// Configuration register file: preamp gain and EQ enable behind an APB-style port.
// Depends on bqeq_pkg.
`default_nettype none
module bqeq_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bqeq_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [bqeq_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [bqeq_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready,
   output logic      [bqeq_pkg::GAIN_W-1:0]   preamp_gain,
   output logic                               eq_enable
);

   logic [bqeq_pkg::GAIN_W-1:0] preamp_gain_ff;
   logic                        eq_enable_ff;
   logic                        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamp_gain_ff <= bqeq_pkg::GAIN_RESET;
         eq_enable_ff   <= 1'b0;
      end else if (wr_en) begin
         if (csr_paddr[2] == bqeq_pkg::REG_PREAMP_GAIN) begin
            preamp_gain_ff <= csr_pwdata[bqeq_pkg::GAIN_W-1:0];
         end else begin
            eq_enable_ff <= csr_pwdata[0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == bqeq_pkg::REG_EQ_ENABLE) begin
         csr_prdata = {{(bqeq_pkg::CSR_DW-1){1'b0}}, eq_enable_ff};
      end else begin
         csr_prdata = {{(bqeq_pkg::CSR_DW-bqeq_pkg::GAIN_W){1'b0}}, preamp_gain_ff};
      end
   end

   assign preamp_gain = preamp_gain_ff;
   assign eq_enable   = eq_enable_ff;

endmodule
`default_nettype wire

// ===== hdl/bqeq_ctrl.sv =====
// Controller state machine: sequences preamp, per-band products and history write-back.
// Depends on bqeq_pkg; drives the datapath through cmd_type and reads status_type.
`default_nettype none
module bqeq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire bqeq_pkg::status_type   status,
   output bqeq_pkg::cmd_type           cmd
);

   bqeq_pkg::state_type          state_ff, state_in;
   logic [bqeq_pkg::BAND_CW-1:0] band_ff, band_in;
   logic [2:0]                   step_ff, step_in;

   always_comb begin
      state_in      = state_ff;
      band_in       = band_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.band      = band_ff;
      cmd.step      = step_ff;
      cmd.coef_step = step_ff;
      req_tready    = (state_ff == bqeq_pkg::ST_IDLE);
      case (state_ff)
         bqeq_pkg::ST_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid && status.sample_ok) begin
               state_in = bqeq_pkg::ST_PRE;
            end
         end
         bqeq_pkg::ST_PRE: begin
            cmd.pre = 1'b1;
            if (status.run_eq) begin
               state_in = bqeq_pkg::ST_RD;
               band_in  = '0;
               step_in  = bqeq_pkg::STEP_B0X;
            end else begin
               state_in = bqeq_pkg::ST_OUT;
            end
         end
         bqeq_pkg::ST_RD: begin
            cmd.hist_rd = 1'b1;
            cmd.coef_rd = 1'b1;
            state_in    = bqeq_pkg::ST_MLO;
         end
         bqeq_pkg::ST_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = bqeq_pkg::ST_MHI;
         end
         bqeq_pkg::ST_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = bqeq_pkg::ST_RND;
         end
         bqeq_pkg::ST_RND: begin
            cmd.round = 1'b1;
            if (step_ff != bqeq_pkg::STEP_A2Y) begin
               cmd.coef_rd   = 1'b1;
               cmd.coef_step = step_ff + 3'd1;
            end
            state_in = bqeq_pkg::ST_ACC;
         end
         bqeq_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            if (step_ff == bqeq_pkg::STEP_A2Y) begin
               state_in = bqeq_pkg::ST_WB;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = bqeq_pkg::ST_MLO;
            end
         end
         bqeq_pkg::ST_WB: begin
            cmd.wb = 1'b1;
            if (band_ff == bqeq_pkg::BAND_CW'(bqeq_pkg::BANDS - 1)) begin
               state_in = bqeq_pkg::ST_OUT;
            end else begin
               band_in  = band_ff + 1'b1;
               step_in  = bqeq_pkg::STEP_B0X;
               state_in = bqeq_pkg::ST_RD;
            end
         end
         bqeq_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bqeq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bqeq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqeq_pkg::ST_IDLE;
         band_ff  <= '0;
         step_ff  <= bqeq_pkg::STEP_B0X;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         step_ff  <= step_in;
      end
   end

   a_wb_after_last_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqeq_pkg::ST_WB) |-> (step_ff == bqeq_pkg::STEP_A2Y))
      else $error("write-back before last product");

   a_acc_after_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqeq_pkg::ST_ACC) |-> $past(state_ff == bqeq_pkg::ST_RND))
      else $error("accumulate without rounded product");

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.sample_ok) |=> (state_ff == bqeq_pkg::ST_PRE))
      else $error("accepted sample did not start");

   a_rd_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqeq_pkg::ST_RD) |->
      ($past(state_ff) == bqeq_pkg::ST_PRE || $past(state_ff) == bqeq_pkg::ST_WB))
      else $error("band read entered out of order");

endmodule
`default_nettype wire

// ===== hdl/bqeq_dp.sv =====
// Datapath: coefficient and history memories, shared split multiplier, accumulator,
// saturation and output register. Depends on bqeq_pkg; steered by bqeq_ctrl.
`default_nettype none
module bqeq_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [bqeq_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire logic [1:0]                            req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [bqeq_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                       rsp_tuser,
   input  wire logic [bqeq_pkg::GAIN_W-1:0]           preamp_gain,
   input  wire logic                                  eq_enable,
   input  wire bqeq_pkg::cmd_type                     cmd,
   output bqeq_pkg::status_type                       status
);

   logic                                 req_ch;
   logic signed [bqeq_pkg::SAMPLE_W-1:0] req_sample;
   logic [3:0]                           req_band;
   logic [2:0]                           req_slot;
   logic [bqeq_pkg::COEF_W-1:0]          req_coef;

   logic [bqeq_pkg::COEF_W-1:0]  coef_mem [bqeq_pkg::COEF_DEPTH];
   logic [bqeq_pkg::COEF_DEPTH-1:0] coef_vld_ff;
   logic [bqeq_pkg::HIST_W-1:0]  hist1_mem [bqeq_pkg::HIST_DEPTH];
   logic [bqeq_pkg::HIST_W-1:0]  hist2_mem [bqeq_pkg::HIST_DEPTH];
   logic [bqeq_pkg::HIST_DEPTH-1:0] hist_vld_ff;

   logic                                 frame_loaded_ff;
   logic                                 ch_ff;
   logic signed [bqeq_pkg::SAMPLE_W-1:0] samp_ff;
   logic [bqeq_pkg::COEF_W-1:0]          coef_rd_ff;
   logic                                 coef_vld_rd_ff;
   logic [bqeq_pkg::HIST_W-1:0]          z1_rd_ff, z2_rd_ff;
   logic                                 hist_vld_rd_ff;
   logic signed [bqeq_pkg::HIST_W-1:0]   x_ff, y_ff, z1n_ff, z2n_ff;
   logic signed [bqeq_pkg::LO_W-1:0]     lo_ff;
   logic signed [bqeq_pkg::HI_W-1:0]     hi_ff;
   logic signed [bqeq_pkg::ACC_W-1:0]    prod_ff, acc_ff;
   logic                                 clip_ff;
   logic                                 out_vld_ff;
   logic                                 out_ch_ff;
   logic [bqeq_pkg::SAMPLE_W-1:0]        out_samp_ff;
   logic                                 out_clip_ff;

   logic                                 coef_wr;
   logic [bqeq_pkg::COEF_AW-1:0]         coef_wr_addr, coef_rd_addr;
   logic [bqeq_pkg::HIST_AW-1:0]         hist_addr;
   logic signed [bqeq_pkg::COEF_W-1:0]   coef_val;
   logic signed [bqeq_pkg::HIST_W-1:0]   z1_val, z2_val, opnd;
   logic signed [bqeq_pkg::LO_W-1:0]     mul_lo;
   logic signed [bqeq_pkg::HI_W-1:0]     mul_hi;
   logic signed [bqeq_pkg::FULL_W-1:0]   full;
   logic signed [bqeq_pkg::PRE_W-1:0]    pre_prod;
   logic signed [bqeq_pkg::PRE_W:0]      pre_sum;
   logic signed [bqeq_pkg::ACC_W-1:0]    sum_y, sum_z1, sum_z2;
   bqeq_pkg::hsat_type                   sat_y, sat_z1, sat_z2;
   bqeq_pkg::osat_type                   sat_o;

   assign req_ch     = req_tdata[0];
   assign req_sample = req_tdata[24:1];
   assign req_band   = req_tdata[28:25];
   assign req_slot   = req_tdata[31:29];
   assign req_coef   = req_tdata[63:32];

   assign coef_wr = cmd.accept && (req_tuser == bqeq_pkg::KIND_COEF)
                    && (int'(req_band) < bqeq_pkg::BANDS)
                    && (int'(req_slot) < bqeq_pkg::SLOTS);
   assign coef_wr_addr = bqeq_pkg::COEF_AW'(int'(req_band) * bqeq_pkg::SLOTS + int'(req_slot));
   assign coef_rd_addr = bqeq_pkg::COEF_AW'(int'(cmd.band) * bqeq_pkg::SLOTS
                         + int'(bqeq_pkg::step_slot(cmd.coef_step)));
   assign hist_addr    = bqeq_pkg::HIST_AW'(int'(ch_ff) * bqeq_pkg::BANDS + int'(cmd.band));

   assign status.sample_ok = (req_tuser == bqeq_pkg::KIND_SAMPLE)
                             && (int'(req_ch) < bqeq_pkg::CHANNELS);
   assign status.run_eq    = frame_loaded_ff && eq_enable;
   assign status.out_free  = !out_vld_ff || rsp_tready;

   assign coef_val = coef_vld_rd_ff ? $signed(coef_rd_ff) : '0;
   assign z1_val   = hist_vld_rd_ff ? $signed(z1_rd_ff) : '0;
   assign z2_val   = hist_vld_rd_ff ? $signed(z2_rd_ff) : '0;
   assign opnd     = (cmd.step == bqeq_pkg::STEP_A1Y || cmd.step == bqeq_pkg::STEP_A2Y)
                     ? y_ff : x_ff;

   assign mul_lo = $signed({1'b0, opnd[bqeq_pkg::SPLIT-1:0]}) * coef_val;
   assign mul_hi = $signed(opnd[bqeq_pkg::HIST_W-1:bqeq_pkg::SPLIT]) * coef_val;
   assign full   = (bqeq_pkg::FULL_W'(hi_ff) <<< bqeq_pkg::SPLIT) + bqeq_pkg::FULL_W'(lo_ff)
                   + (bqeq_pkg::FULL_W'(1) <<< (bqeq_pkg::COEF_FRAC_BITS - 1));

   assign pre_prod = samp_ff * $signed({1'b0, preamp_gain});
   assign pre_sum  = (bqeq_pkg::PRE_W + 1)'(pre_prod)
                     + ((bqeq_pkg::PRE_W + 1)'(1) <<< (bqeq_pkg::GAIN_FRAC - 1));

   assign sum_y  = prod_ff + bqeq_pkg::ACC_W'(z1_val);
   assign sum_z1 = acc_ff - prod_ff + bqeq_pkg::ACC_W'(z2_val);
   assign sum_z2 = acc_ff - prod_ff;
   assign sat_y  = bqeq_pkg::sat_hist(sum_y);
   assign sat_z1 = bqeq_pkg::sat_hist(sum_z1);
   assign sat_z2 = bqeq_pkg::sat_hist(sum_z2);
   assign sat_o  = bqeq_pkg::sat_out(x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff     <= '0;
         hist_vld_ff     <= '0;
         frame_loaded_ff <= 1'b0;
         out_vld_ff      <= 1'b0;
      end else begin
         if (cmd.accept && req_tuser == bqeq_pkg::KIND_COEF) begin
            frame_loaded_ff <= 1'b1;
         end
         if (coef_wr) begin
            coef_vld_ff[coef_wr_addr] <= 1'b1;
         end
         if (cmd.accept && req_tuser == bqeq_pkg::KIND_CLEAR) begin
            hist_vld_ff <= '0;
         end else if (cmd.wb) begin
            hist_vld_ff[hist_addr] <= 1'b1;
         end
         if (cmd.out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (coef_wr) begin
         coef_mem[coef_wr_addr] <= req_coef;
      end
      if (cmd.coef_rd) begin
         coef_rd_ff     <= coef_mem[coef_rd_addr];
         coef_vld_rd_ff <= coef_vld_ff[coef_rd_addr];
      end
      if (cmd.wb) begin
         hist1_mem[hist_addr] <= z1n_ff;
         hist2_mem[hist_addr] <= z2n_ff;
      end
      if (cmd.hist_rd) begin
         z1_rd_ff       <= hist1_mem[hist_addr];
         z2_rd_ff       <= hist2_mem[hist_addr];
         hist_vld_rd_ff <= hist_vld_ff[hist_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff   <= req_ch;
         samp_ff <= req_sample;
      end
      if (cmd.pre) begin
         clip_ff <= 1'b0;
         if (frame_loaded_ff) begin
            x_ff <= bqeq_pkg::HIST_W'($signed(pre_sum[bqeq_pkg::PRE_W:bqeq_pkg::GAIN_FRAC]));
         end else begin
            x_ff <= bqeq_pkg::HIST_W'(samp_ff);
         end
      end else if (cmd.wb) begin
         x_ff <= y_ff;
      end
      if (cmd.mul_lo) begin
         lo_ff <= mul_lo;
      end
      if (cmd.mul_hi) begin
         hi_ff <= mul_hi;
      end
      if (cmd.round) begin
         prod_ff <= bqeq_pkg::ACC_W'(full >>> bqeq_pkg::COEF_FRAC_BITS);
      end
      if (cmd.acc) begin
         case (cmd.step)
            bqeq_pkg::STEP_B0X: begin
               y_ff    <= sat_y.val;
               clip_ff <= clip_ff | sat_y.clip;
            end
            bqeq_pkg::STEP_B1X, bqeq_pkg::STEP_B2X: begin
               acc_ff <= prod_ff;
            end
            bqeq_pkg::STEP_A1Y: begin
               z1n_ff  <= sat_z1.val;
               clip_ff <= clip_ff | sat_z1.clip;
            end
            bqeq_pkg::STEP_A2Y: begin
               z2n_ff  <= sat_z2.val;
               clip_ff <= clip_ff | sat_z2.clip;
            end
            default: begin
               acc_ff <= prod_ff;
            end
         endcase
      end
      if (cmd.out_load) begin
         out_ch_ff   <= ch_ff;
         out_samp_ff <= sat_o.val;
         out_clip_ff <= clip_ff | sat_o.clip;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(bqeq_pkg::RSP_TDATA_W - bqeq_pkg::SAMPLE_W - 1){1'b0}},
                        out_samp_ff, out_ch_ff};
   assign rsp_tuser  = out_clip_ff;

endmodule
`default_nettype wire

// ===== hdl/biquad_cascade_equalizer_top.sv =====
// Biquad cascade equalizer top level: register file, controller and datapath.
// Depends on bqeq_pkg, bqeq_csr, bqeq_ctrl and bqeq_dp.
//
// A sample transaction (tuser kind 0) is scaled by the preamp gain once coefficients
// have been loaded (else it passes unscaled) and, with the EQ enabled, runs through the
// configured bands in transposed direct form II; one result follows per sample whose
// channel exists. Coefficient writes and history clears give no result. A filtered
// sample is computed with a split 21x32 / 20x32 multiply doing five rounded products per
// band, each in four steps; preamp-only or unloaded samples skip the bands. The next
// transaction is taken while a finished result still waits on the output register.
`default_nettype none
module biquad_cascade_equalizer_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tdata: channel, sample_in[24:1], band_select[28:25], coeff_slot[31:29],
   //        coeff_value[63:32]
   input  wire logic [bqeq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: kind[1:0]
   input  wire logic [1:0]                         req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: out_channel, sample_out[24:1], zero fill
   output logic      [bqeq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // tuser: clipped
   output logic                                    rsp_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bqeq_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [bqeq_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic      [bqeq_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                                    csr_pready
);

   logic [bqeq_pkg::GAIN_W-1:0] preamp_gain;
   logic                        eq_enable;
   bqeq_pkg::cmd_type           cmd;
   bqeq_pkg::status_type        status;

   bqeq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .preamp_gain (preamp_gain),
      .eq_enable   (eq_enable)
   );

   bqeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bqeq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .preamp_gain (preamp_gain),
      .eq_enable   (eq_enable),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire
